// ===== rtl/mbpa_pkg.sv =====
package mbpa_pkg;

  // Defaults for the top level parameters.
  localparam int unsigned CalibDepthDef = 128;
  localparam int unsigned WindowMaxDef  = 64;
  localparam int unsigned CalibHoursDef = 24;

  // Fixed field widths.
  localparam int unsigned PhW      = 12;
  localparam int unsigned TempW    = 16;
  localparam int unsigned UpW      = 16;
  localparam int unsigned CfgCntW  = 7;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 2;

  // Register values after reset.
  localparam logic [PhW-1:0]            PhLimitRst   = 12'd1792;
  localparam logic signed [TempW-1:0]   TempRiseRst  = 16'sd512;
  localparam logic [CfgCntW-1:0]        WinLenRst    = 7'd48;
  localparam logic [CfgCntW-1:0]        ReqCountRst  = 7'd36;

  // Flipping the sign bit turns a signed compare into an unsigned one.
  localparam logic [TempW-1:0] SignFlip = 16'h8000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PH_LIMIT  = 2'd0,
    REG_TEMP_RISE = 2'd1,
    REG_WIN_LEN   = 2'd2,
    REG_REQ_COUNT = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    STATUS_CALIB = 2'd0,
    STATUS_FILL  = 2'd1,
    STATUS_EVAL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SELECT,
    S_EVAL,
    S_COUNT,
    S_DONE
  } seq_state_e;

endpackage

// ===== rtl/median_baseline_persistence_alert.sv =====
// Channel  | Direction | Handshake                 | Payload
// ---------+-----------+---------------------------+------------------------------------------
// in       | input     | in_valid_i / in_stall_o   | ph_sample_i, temp_sample_i, uptime_i
// out      | output    | out_valid_o / out_stall_i | alert_o, status_o, violation_total_o,
//          |           |                           | window_fill_o, baseline_temp_o
// cfg      | input     | cfg_we_i (no stall)       | cfg_idx_i, cfg_data_i
//
// A calibration sample that does not lock passes through the decide and done states to its result.
// The locking sample runs a bitwise median search: sixteen passes over the n stored
// samples through the single read port of the calibration memory, followed by the
// window evaluation below. After lock a sample waits on the window counter, which adds
// one violation bit per cycle over the filled part of the window.
// Reset is asynchronous and active low; it clears the control state and loads the
// register defaults. The calibration memory and violation bits need no clearing.
// The block takes the next input transaction while a result is still stalled; the
// result of that next transaction waits in the sequencer until the output is free.
module median_baseline_persistence_alert
  import mbpa_pkg::*;
#(
  parameter int unsigned CALIB_DEPTH = CalibDepthDef,
  parameter int unsigned WINDOW_MAX  = WindowMaxDef,
  parameter int unsigned CALIB_HOURS = CalibHoursDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,

  input  logic                                  cfg_we_i,
  input  logic [CfgIdxW-1:0]                    cfg_idx_i,
  input  logic [CfgDataW-1:0]                   cfg_data_i,

  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [PhW-1:0]                        ph_sample_i,
  input  logic signed [TempW-1:0]               temp_sample_i,
  input  logic [UpW-1:0]                        uptime_i,

  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic                                  alert_o,
  output logic [1:0]                            status_o,
  output logic [$clog2(WINDOW_MAX+1)-1:0]       violation_total_o,
  output logic [$clog2(WINDOW_MAX+1)-1:0]       window_fill_o,
  output logic signed [TempW-1:0]               baseline_temp_o
);

  // Widths that follow from the parameters.
  localparam int unsigned CntW  = $clog2(CALIB_DEPTH + 1);
  localparam int unsigned AddrW = $clog2(CALIB_DEPTH);
  localparam int unsigned FillW = $clog2(WINDOW_MAX + 1);
  localparam int unsigned LenW  = (FillW > CfgCntW) ? FillW : CfgCntW;

  localparam logic [CntW-1:0] CalibDepthC = CntW'(CALIB_DEPTH);
  localparam logic [UpW-1:0]  CalibHoursC = UpW'(CALIB_HOURS);
  localparam logic [LenW-1:0] WinMaxC     = LenW'(WINDOW_MAX);

  // Configuration registers.
  logic [PhW-1:0]          ph_limit_q;
  logic signed [TempW-1:0] rise_limit_q;
  logic [CfgCntW-1:0]      win_len_q;
  logic [CfgCntW-1:0]      req_count_q;

  // Sequencer and persistent state.
  seq_state_e              state_q, state_d;
  logic                    locked_q;
  logic [CntW-1:0]         calib_cnt_q;
  logic signed [TempW-1:0] baseline_q;
  logic [FillW-1:0]        fill_q;
  logic [FillW-1:0]        hit_q;

  // Captured input transaction.
  logic [PhW-1:0]          ph_q;
  logic signed [TempW-1:0] temp_q;
  logic [UpW-1:0]          up_q;

  // Calibration memory with a registered read port.
  logic [TempW-1:0]        calib_mem [CALIB_DEPTH];
  logic [TempW-1:0]        rdata_q;

  // Median search: the result is built one bit per pass, most significant first.
  logic [CntW-1:0]         sel_addr_q;
  logic                    rd_vld_q;
  logic [CntW-1:0]         sel_cnt_q;
  logic [CntW-1:0]         rank_q;
  logic [TempW-1:0]        prefix_q;
  logic [TempW-1:0]        onehot_q;
  logic [TempW-1:0]        mask_q;

  // Violation window and its counter.
  logic [WINDOW_MAX-1:0]   vbits_q;
  logic [WINDOW_MAX-1:0]   scratch_q;
  logic [FillW-1:0]        widx_q;
  logic [FillW-1:0]        wcnt_q;
  logic [FillW-1:0]        len_q;

  // Result of the transaction in progress, and the output register.
  logic                    res_alert_q;
  status_e                 res_status_q;
  logic                    out_valid_q;
  logic                    out_alert_q;
  status_e                 out_status_q;
  logic [FillW-1:0]        out_hits_q;
  logic [FillW-1:0]        out_fill_q;
  logic signed [TempW-1:0] out_base_q;

  logic                    in_accept;
  logic                    calib_store_en;
  logic                    out_free;
  logic [TempW-1:0]        key;
  logic                    key_match;
  logic                    pass_end;
  logic                    bit_one;
  logic [TempW-1:0]        prefix_next;
  logic                    count_more;
  logic [LenW-1:0]         wl_ext;
  logic [LenW-1:0]         len_full;
  logic [FillW-1:0]        eff_len;
  logic [FillW:0]          fill_inc;
  logic [FillW-1:0]        fill_new;
  logic signed [TempW:0]   temp_diff;
  logic signed [TempW:0]   rise_ext;
  logic                    violation;

  assign in_stall_o     = (state_q != S_IDLE);
  assign in_accept      = in_valid_i && !in_stall_o;
  assign calib_store_en = in_accept && !locked_q && (calib_cnt_q < CalibDepthC);
  assign out_free       = !out_valid_q || !out_stall_i;

  // One sample matches when it agrees with the bits found so far and has a zero
  // in the bit under test. Samples are compared in offset binary.
  assign key         = rdata_q ^ SignFlip;
  assign key_match   = ((key & mask_q) == prefix_q) && ((key & onehot_q) == '0);
  assign pass_end    = !rd_vld_q && (sel_addr_q == calib_cnt_q);
  assign bit_one     = (rank_q >= sel_cnt_q);
  assign prefix_next = bit_one ? (prefix_q | onehot_q) : prefix_q;

  assign count_more = (widx_q < fill_q);

  // Window length as used: zero counts as one and it never exceeds the window.
  assign wl_ext   = LenW'(win_len_q);
  assign len_full = (wl_ext == '0) ? LenW'(1) : ((wl_ext > WinMaxC) ? WinMaxC : wl_ext);
  assign eff_len  = FillW'(len_full);
  assign fill_inc = {1'b0, fill_q} + (FillW+1)'(1);
  assign fill_new = (fill_inc > {1'b0, eff_len}) ? eff_len : fill_inc[FillW-1:0];

  // The rise over baseline is formed one bit wider so that it cannot wrap.
  assign temp_diff = {temp_q[TempW-1], temp_q} - {baseline_q[TempW-1], baseline_q};
  assign rise_ext  = {rise_limit_q[TempW-1], rise_limit_q};
  assign violation = (ph_q > ph_limit_q) && (temp_diff > rise_ext);

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (locked_q) begin
          state_d = S_EVAL;
        end else if (up_q >= CalibHoursC) begin
          state_d = S_SELECT;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SELECT: begin
        if (pass_end && onehot_q[0]) state_d = S_EVAL;
      end
      S_EVAL: begin
        state_d = S_COUNT;
      end
      S_COUNT: begin
        if (!count_more) state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state, configuration and the persistent counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      ph_limit_q   <= PhLimitRst;
      rise_limit_q <= TempRiseRst;
      win_len_q    <= WinLenRst;
      req_count_q  <= ReqCountRst;
      locked_q     <= 1'b0;
      calib_cnt_q  <= '0;
      baseline_q   <= '0;
      fill_q       <= '0;
      hit_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_PH_LIMIT:  ph_limit_q   <= cfg_data_i[PhW-1:0];
          REG_TEMP_RISE: rise_limit_q <= cfg_data_i[TempW-1:0];
          REG_WIN_LEN:   win_len_q    <= cfg_data_i[CfgCntW-1:0];
          REG_REQ_COUNT: req_count_q  <= cfg_data_i[CfgCntW-1:0];
          default: ;
        endcase
      end

      if (calib_store_en) calib_cnt_q <= calib_cnt_q + CntW'(1);

      // The last pass settles the lowest bit, and with it the baseline.
      if (state_q == S_SELECT && pass_end && onehot_q[0]) begin
        baseline_q <= prefix_next ^ SignFlip;
        locked_q   <= 1'b1;
      end

      if (state_q == S_EVAL) fill_q <= fill_new;
      if (state_q == S_COUNT && !count_more) hit_q <= wcnt_q;

      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Calibration memory.
  always_ff @(posedge clk_i) begin
    if (calib_store_en) calib_mem[calib_cnt_q[AddrW-1:0]] <= temp_sample_i;
    rdata_q <= calib_mem[sel_addr_q[AddrW-1:0]];
  end

  // Datapath of the sequencer.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      ph_q   <= ph_sample_i;
      temp_q <= temp_sample_i;
      up_q   <= uptime_i;
    end

    case (state_q)
      S_DECIDE: begin
        // Rank of the upper median among the stored samples.
        sel_addr_q   <= '0;
        rd_vld_q     <= 1'b0;
        sel_cnt_q    <= '0;
        rank_q       <= calib_cnt_q >> 1;
        prefix_q     <= '0;
        onehot_q     <= SignFlip;
        mask_q       <= '0;
        res_alert_q  <= 1'b0;
        res_status_q <= STATUS_CALIB;
      end
      S_SELECT: begin
        if (pass_end) begin
          // A match count no larger than the rank means the wanted sample has a one here.
          prefix_q   <= prefix_next;
          if (bit_one) rank_q <= rank_q - sel_cnt_q;
          onehot_q   <= onehot_q >> 1;
          mask_q     <= mask_q | onehot_q;
          sel_addr_q <= '0;
          sel_cnt_q  <= '0;
          rd_vld_q   <= 1'b0;
        end else begin
          rd_vld_q <= (sel_addr_q < calib_cnt_q);
          if (sel_addr_q < calib_cnt_q) sel_addr_q <= sel_addr_q + CntW'(1);
          if (rd_vld_q && key_match) sel_cnt_q <= sel_cnt_q + CntW'(1);
        end
      end
      S_EVAL: begin
        vbits_q   <= {vbits_q[WINDOW_MAX-2:0], violation};
        scratch_q <= {vbits_q[WINDOW_MAX-2:0], violation};
        len_q     <= eff_len;
        widx_q    <= '0;
        wcnt_q    <= '0;
      end
      S_COUNT: begin
        if (count_more) begin
          wcnt_q    <= wcnt_q + FillW'(scratch_q[0]);
          scratch_q <= scratch_q >> 1;
          widx_q    <= widx_q + FillW'(1);
        end else if (fill_q >= len_q) begin
          res_alert_q  <= (LenW'(wcnt_q) >= LenW'(req_count_q));
          res_status_q <= STATUS_EVAL;
        end else begin
          res_alert_q  <= 1'b0;
          res_status_q <= STATUS_FILL;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_alert_q  <= res_alert_q;
          out_status_q <= res_status_q;
          out_hits_q   <= hit_q;
          out_fill_q   <= fill_q;
          out_base_q   <= baseline_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o       = out_valid_q;
  assign alert_o           = out_alert_q;
  assign status_o          = out_status_q;
  assign violation_total_o = out_hits_q;
  assign window_fill_o     = out_fill_q;
  assign baseline_temp_o   = out_base_q;

endmodule

// ===== rtl/mbpa_checker.sv =====
module mbpa_checker
  import mbpa_pkg::*;
#(
  parameter int unsigned WINDOW_MAX = WindowMaxDef
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic                             alert_o,
  input logic [1:0]                       status_o,
  input logic [$clog2(WINDOW_MAX+1)-1:0]  violation_total_o,
  input logic [$clog2(WINDOW_MAX+1)-1:0]  window_fill_o,
  input logic signed [TempW-1:0]          baseline_temp_o
);

  // A stalled result stays offered and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(alert_o) && $stable(status_o)
      && $stable(violation_total_o) && $stable(window_fill_o) && $stable(baseline_temp_o))
    else $error("stalled result changed");

  // While calibrating the window is empty and no baseline is shown.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STATUS_CALIB) |-> !alert_o && (window_fill_o == '0)
      && (violation_total_o == '0) && (baseline_temp_o == '0))
    else $error("calibration result carries window data");

  // An alert is only raised on an evaluated window.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && alert_o |-> (status_o == STATUS_EVAL))
    else $error("alert without a full window");

  // The violation count never exceeds the samples held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (violation_total_o <= window_fill_o))
    else $error("violation count above window fill");

endmodule

bind median_baseline_persistence_alert mbpa_checker #(
  .WINDOW_MAX(WINDOW_MAX)
) u_mbpa_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .alert_o           (alert_o),
  .status_o          (status_o),
  .violation_total_o (violation_total_o),
  .window_fill_o     (window_fill_o),
  .baseline_temp_o   (baseline_temp_o)
);

// ===== dv/testbench.sv =====
module testbench;
  import mbpa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Width of the window counters on the result ports.
  localparam int unsigned CntW = $clog2(WindowMaxDef + 1);

  // The locking transaction walks the calibration store sixteen times, and the
  // deliberate receiver hold-off below adds a quiet stretch of its own. The limit
  // leaves a wide margin over both.
  localparam int StallLimit = 20000;

  // The long receiver hold-off is placed once the run is well past the lock. It is
  // only started while plenty of readings are still waiting to be sent.
  localparam int HoldAfter  = 370;
  localparam int HoldCycles = 300;

  // The drain at the end waits out the count of the longest window, so that any stray
  // result still has time to show up.
  localparam int DrainCycles = 100;

  typedef struct packed {
    logic [PhW-1:0]          ph;
    logic signed [TempW-1:0] temp;
    logic [UpW-1:0]          uptime;
  } reading_t;

  typedef struct packed {
    logic                    alert;
    status_e                 status;
    logic [CntW-1:0]         viol_total;
    logic [CntW-1:0]         fill;
    logic signed [TempW-1:0] baseline;
  } verdict_t;

  // Signals to and from the block. Everything the testbench drives starts at a
  // known value.
  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  cfg_reg_e                cfg_idx = REG_PH_LIMIT;
  logic [CfgDataW-1:0]     cfg_data_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic [PhW-1:0]          ph_sample_i = '0;
  logic signed [TempW-1:0] temp_sample_i = '0;
  logic [UpW-1:0]          uptime_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic                    alert_o;
  logic [1:0]              status_o;
  logic [CntW-1:0]         violation_total_o;
  logic [CntW-1:0]         window_fill_o;
  logic signed [TempW-1:0] baseline_temp_o;

  median_baseline_persistence_alert uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .ph_sample_i       (ph_sample_i),
    .temp_sample_i     (temp_sample_i),
    .uptime_i          (uptime_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .alert_o           (alert_o),
    .status_o          (status_o),
    .violation_total_o (violation_total_o),
    .window_fill_o     (window_fill_o),
    .baseline_temp_o   (baseline_temp_o)
  );

  // ---------------------------------------------------------------------------
  // Shadow of the alert engine. The register copies follow the writes seen on
  // the configuration port; the rest follows every accepted input transaction.
  // ---------------------------------------------------------------------------
  logic [PhW-1:0]          lim_ph    = PhLimitRst;
  logic signed [TempW-1:0] lim_rise  = TempRiseRst;
  logic [CfgCntW-1:0]      win_len   = WinLenRst;
  logic [CfgCntW-1:0]      req_count = ReqCountRst;

  logic signed [TempW-1:0] calib_temps [CalibDepthDef];
  int                      calib_n  = 0;
  logic signed [TempW-1:0] base     = '0;
  bit                      locked_q = 1'b0;
  bit                      hist [WindowMaxDef];
  int                      fill_q   = 0;
  int                      hits_q   = 0;
  bit                      alert_q  = 1'b0;

  // Bookkeeping shared by the processes below.
  reading_t reading_queue [$];
  verdict_t pending_verdicts [$];
  int       items_queued    = 0;
  int       items_accepted  = 0;
  int       results_checked = 0;
  int       mismatches      = 0;
  int       idle_cycles     = 0;
  int       viol_seen       = 0;
  int       alerts_seen     = 0;
  int       settings_used   = 1;
  bit       in_taken        = 1'b0;
  bit       out_taken       = 1'b0;

  // Saturate a wide value into the temperature range.
  function automatic logic signed [TempW-1:0] to_temp(int t);
    if (t > 32767) return 16'sh7fff;
    if (t < -32768) return 16'sh8000;
    return 16'(t);
  endfunction

  // Advance the shadow by one reading and return the result it must produce.
  function automatic verdict_t next_verdict(reading_t s);
    verdict_t                v;
    logic signed [TempW-1:0] sorted [CalibDepthDef];
    logic signed [TempW-1:0] key;
    int                      i;
    int                      j;
    int                      len;
    int                      diff;
    bit                      hit;
    v = '0;
    v.status = STATUS_CALIB;
    if (!locked_q) begin
      // Samples that arrive once the store is full are simply lost.
      if (calib_n < CalibDepthDef) begin
        calib_temps[calib_n] = s.temp;
        calib_n++;
      end
      if (s.uptime >= CalibHoursDef) begin
        // Upper median: element n/2 of the stored samples in ascending order.
        for (i = 0; i < calib_n; i++) begin
          key = calib_temps[i];
          j = i;
          while (j > 0 && sorted[j-1] > key) begin
            sorted[j] = sorted[j-1];
            j--;
          end
          sorted[j] = key;
        end
        base = sorted[calib_n/2];
        locked_q = 1'b1;
      end
    end
    if (locked_q) begin
      len = int'(win_len);
      if (len == 0) len = 1;
      if (len > WindowMaxDef) len = WindowMaxDef;
      // The rise over baseline is taken at full precision; it must never wrap.
      diff = int'(s.temp) - int'(base);
      hit = (s.ph > lim_ph) && (diff > int'(lim_rise));
      if (hit) viol_seen++;
      for (i = WindowMaxDef - 1; i > 0; i--) hist[i] = hist[i-1];
      hist[0] = hit;
      fill_q++;
      if (fill_q > len) fill_q = len;
      hits_q = 0;
      for (i = 0; i < fill_q; i++) hits_q += int'(hist[i]);
      if (fill_q >= len) begin
        alert_q = (hits_q >= int'(req_count));
        v.alert = alert_q;
        v.status = STATUS_EVAL;
        if (alert_q) alerts_seen++;
      end else begin
        v.status = STATUS_FILL;
      end
    end
    v.viol_total = CntW'(hits_q);
    v.fill = CntW'(fill_q);
    v.baseline = base;
    return v;
  endfunction

  // Clock.
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Monitor. Everything is sampled at the rising edge, where the testbench's own
  // signals have been stable since the falling edge. A transaction on the input
  // side is turned into an expected result straight away; a transaction on the
  // output side is compared with the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken  <= in_valid_i && !in_stall_o;
      out_taken <= out_valid_o && !out_stall_i;

      if (cfg_we_i) begin
        case (cfg_idx)
          REG_PH_LIMIT:  lim_ph    = cfg_data_i[PhW-1:0];
          REG_TEMP_RISE: lim_rise  = cfg_data_i;
          REG_WIN_LEN:   win_len   = cfg_data_i[CfgCntW-1:0];
          REG_REQ_COUNT: req_count = cfg_data_i[CfgCntW-1:0];
          default: ;
        endcase
      end

      if (in_valid_i && !in_stall_o) begin
        pending_verdicts = {pending_verdicts,
                            next_verdict({ph_sample_i, temp_sample_i, uptime_i})};
        items_accepted++;
      end

      if (out_valid_o && !out_stall_i) begin
        if (pending_verdicts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"[%0t] result with nothing expected: alert=%0d status=%0d ",
                      "total=%0d fill=%0d base=%0d"},
                     $realtime, alert_o, status_o, violation_total_o, window_fill_o,
                     baseline_temp_o);
        end else begin
          verdict_t want;
          want = pending_verdicts[0];
          pending_verdicts.delete(0);
          results_checked++;
          if (want.alert !== alert_o || want.status !== status_o ||
              want.viol_total !== violation_total_o || want.fill !== window_fill_o ||
              want.baseline !== baseline_temp_o) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"[%0t] result %0d differs: expected alert=%0d status=%0d total=%0d ",
                        "fill=%0d base=%0d, got alert=%0d status=%0d total=%0d fill=%0d base=%0d"},
                       $realtime, results_checked, want.alert, want.status, want.viol_total,
                       want.fill, want.baseline, alert_o, status_o, violation_total_o,
                       window_fill_o, baseline_temp_o);
          end
        end
      end

      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver. Readings are taken from the queue that the stimulus process fills.
  // A reading stays on the port unchanged until it is accepted; then the driver
  // waits its drawn number of cycles before offering the next one. The calm flag
  // gives stretches of back-to-back transactions.
  // ---------------------------------------------------------------------------
  reading_t next_reading;
  int       send_wait = 0;
  bit       send_calm = 1'b0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid_i <= 1'b0;
        end else if (reading_queue.size() != 0) begin
          next_reading = reading_queue[0];
          reading_queue.delete(0);
          ph_sample_i   <= next_reading.ph;
          temp_sample_i <= next_reading.temp;
          uptime_i      <= next_reading.uptime;
          in_valid_i    <= 1'b1;
          if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
          send_wait = send_calm ? 0 : $urandom_range(0, 14);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver. After each result it stalls for a drawn number of cycles in which a
  // result is on offer. Once in the run it holds off for a long stretch, so that
  // the block has to park a finished result and push back on its input.
  // ---------------------------------------------------------------------------
  int recv_wait = 0;
  int hold_left = 0;
  bit recv_calm = 1'b0;
  bit hold_done = 1'b0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_taken) begin
        if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
        recv_wait = recv_calm ? 0 : $urandom_range(0, 14);
        if (!hold_done && results_checked >= HoldAfter && reading_queue.size() >= 20) begin
          hold_left = HoldCycles;
          hold_done = 1'b1;
        end
      end else if (recv_wait > 0 && out_valid_o) begin
        recv_wait--;
      end
      if (hold_left > 0) hold_left--;
      out_stall_i <= (hold_left > 0) || (recv_wait > 0);
    end
  end

  // Watchdog: too long without any transaction on either side ends the run.
  initial begin
    wait (idle_cycles >= StallLimit);
    $display("[%0t] no transaction for %0d cycles", $realtime, StallLimit);
    $display("testbench: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  task automatic queue_reading(logic [PhW-1:0] ph, logic signed [TempW-1:0] temp,
                               logic [UpW-1:0] uptime);
    reading_t s;
    s.ph = ph;
    s.temp = temp;
    s.uptime = uptime;
    reading_queue = {reading_queue, s};
    items_queued++;
  endtask

  // Wait until every queued reading has been sent and its result checked.
  task automatic settle();
    wait (items_accepted == items_queued && results_checked == items_queued);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx    <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // The narrow registers get random junk above their width; only the low bits count.
  task automatic set_limits(logic [PhW-1:0] ph, logic signed [TempW-1:0] rise,
                            logic [CfgCntW-1:0] wlen, logic [CfgCntW-1:0] req);
    write_reg(REG_PH_LIMIT, {4'($urandom), ph});
    write_reg(REG_TEMP_RISE, rise);
    write_reg(REG_WIN_LEN, {9'($urandom), wlen});
    write_reg(REG_REQ_COUNT, {9'($urandom), req});
    settings_used++;
  endtask

  // Post-lock readings with random content. The share of readings aimed above both
  // thresholds is redrawn every sixteen readings so that violation runs build up
  // and die away, taking the alert through both values.
  task automatic queue_random(int count);
    int k;
    int hot;
    int roll;
    int thr;
    int span;
    logic [PhW-1:0] ph;
    logic signed [TempW-1:0] temp;
    hot = 50;
    thr = int'(base) + int'(lim_rise);
    for (k = 0; k < count; k++) begin
      if (k % 16 == 0) hot = $urandom_range(0, 100);
      roll = $urandom_range(0, 99);
      if (roll < hot) begin
        ph = (lim_ph == '1) ? lim_ph : PhW'($urandom_range(int'(lim_ph) + 1, 4095));
        if (thr >= 32767) begin
          temp = 16'sh7fff;
        end else begin
          span = (32767 - thr - 1 < 300) ? 32767 - thr - 1 : 300;
          temp = to_temp(thr + 1 + int'($urandom_range(0, span)));
        end
      end else if (roll < hot + 8) begin
        // Right on the thresholds, where a strict compare matters.
        ph = lim_ph + PhW'($urandom_range(0, 1));
        temp = to_temp(thr + int'($urandom_range(0, 1)));
      end else if (roll < hot + 20) begin
        ph = PhW'($urandom);
        temp = TempW'($urandom);
      end else if ($urandom_range(0, 1) == 0) begin
        ph = PhW'($urandom_range(0, int'(lim_ph)));
        temp = TempW'($urandom);
      end else begin
        ph = PhW'($urandom);
        temp = to_temp(thr - int'($urandom_range(0, 300)));
      end
      queue_reading(ph, temp, UpW'($urandom));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  int k;
  int eff_len;
  int thr;

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Calibration: the extremes of every field first, duplicates included, then
    // enough ordinary samples to run past the capacity of the store, so that the
    // last ones are dropped. The locking reading arrives at exactly 24 hours.
    queue_reading(12'd0,    16'sh8000, 16'd0);
    queue_reading(12'd4095, 16'sh7fff, 16'd23);
    queue_reading(12'd0,    16'sd0,    16'd1);
    queue_reading(12'd4095, -16'sd1,   16'd22);
    queue_reading(12'd1792, 16'sd6400, 16'd0);
    queue_reading(12'd1793, 16'sd6400, 16'd12);
    queue_reading(12'hAAA,  16'sd100,  16'd23);
    queue_reading(12'h555,  -16'sd100, 16'd5);
    queue_reading(12'd4095, 16'sh7fff, 16'd0);
    queue_reading(12'd0,    16'sh8000, 16'd23);
    for (k = 0; k < 130; k++) begin
      if ($urandom_range(0, 3) != 0)
        queue_reading(PhW'($urandom), to_temp(6400 + int'($urandom_range(0, 3000)) - 1500),
                      UpW'($urandom_range(0, 23)));
      else
        queue_reading(PhW'($urandom), TempW'($urandom), UpW'($urandom_range(0, 23)));
    end
    queue_reading(PhW'($urandom), 16'sd6400, 16'd24);
    settle();

    // Reset limits. A few readings at the edges: both pH extremes, both
    // temperature extremes (the coldest one gives a rise that needs 17 bits),
    // and readings sitting exactly on each threshold.
    thr = int'(base) + int'(lim_rise);
    queue_reading(12'd4095, 16'sh7fff, 16'hFFFF);
    queue_reading(12'd0, 16'sh7fff, 16'h0000);
    queue_reading(12'd4095, 16'sh8000, 16'h5555);
    queue_reading(lim_ph, to_temp(thr + 100), 16'hAAAA);
    queue_reading(lim_ph + 1'b1, to_temp(thr), 16'h00FF);
    queue_reading(lim_ph + 1'b1, to_temp(thr + 1), 16'hFF00);
    queue_random(84);
    settle();

    // Loosest limits and the shortest window: nearly every reading violates.
    set_limits(12'd0, 16'sh8000, 7'd1, 7'd1);
    queue_random(60);
    settle();

    // Tightest limits, a zero window length taken as one, and a zero count.
    set_limits(12'd4095, 16'sh7fff, 7'd0, 7'd0);
    queue_random(60);
    settle();

    // Longest window with every slot needed; the long hold-off falls in here.
    set_limits(12'd1500, 16'sd0, 7'd64, 7'd64);
    queue_random(120);
    settle();

    // A length above the maximum is taken as the maximum.
    set_limits(12'd2000, 16'sd256, 7'd127, 7'd40);
    queue_random(100);
    settle();

    // Shrink the window: the fill level is cut back at once.
    set_limits(12'd1792, 16'sd512, 7'd10, 7'd7);
    queue_random(80);
    settle();

    // Grow it again with a count the window can never reach.
    set_limits(12'd1792, 16'sd512, 7'd20, 7'd100);
    queue_random(60);
    settle();

    // Random settings, mostly short windows.
    repeat (4) begin
      eff_len = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 16);
      set_limits(PhW'($urandom), TempW'($urandom), CfgCntW'(eff_len),
                 CfgCntW'($urandom_range(0, (eff_len > 64 ? 64 : eff_len) + 3)));
      queue_random(60);
      settle();
    end

    repeat (DrainCycles) @(negedge clk_i);

    $display("Run covered %0d transactions: %0d calibration samples, baseline %0d, %0d settings.",
             results_checked, calib_n, base, settings_used);
    $display("Predicted %0d violations and %0d results with the alert raised; %0d mismatches.",
             viol_seen, alerts_seen, mismatches);
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
